// ===== rtl/assert_macros.svh =====
// assertion macros used by the alu top level module
// no dependencies; expects i_clk and i_rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/xalu_pkg.sv =====
// package for the x86 integer alu: opcodes, size codes, flag positions, helpers
// no dependencies
package xalu_pkg;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_INC = 3'd2;
    localparam logic [2:0] OP_DEC = 3'd3;
    localparam logic [2:0] OP_AND = 3'd4;
    localparam logic [2:0] OP_OR  = 3'd5;
    localparam logic [2:0] OP_XOR = 3'd6;
    localparam logic [2:0] OP_NOT = 3'd7;

    localparam logic [1:0] SZ_8  = 2'd0;
    localparam logic [1:0] SZ_16 = 2'd1;
    localparam logic [1:0] SZ_32 = 2'd2;
    localparam logic [1:0] SZ_64 = 2'd3;

    localparam int FLAG_CF = 0;
    localparam int FLAG_PF = 1;
    localparam int FLAG_AF = 2;
    localparam int FLAG_ZF = 3;
    localparam int FLAG_SF = 4;
    localparam int FLAG_OF = 5;

    typedef logic [63:0] t_word;
    typedef logic [5:0]  t_flags;

    typedef struct packed {
        t_word  result;
        t_flags flags;
    } t_alu_res;

    function automatic t_word size_mask(input logic [1:0] wc);
        t_word m;
        begin
            unique case (wc)
                SZ_8:    m = 64'h0000_0000_0000_00ff;
                SZ_16:   m = 64'h0000_0000_0000_ffff;
                SZ_32:   m = 64'h0000_0000_ffff_ffff;
                default: m = 64'hffff_ffff_ffff_ffff;
            endcase
            return m;
        end
    endfunction

    function automatic logic bit_at_size(input logic [64:0] v, input logic [1:0] wc);
        logic b;
        begin
            unique case (wc)
                SZ_8:    b = v[8];
                SZ_16:   b = v[16];
                SZ_32:   b = v[32];
                default: b = v[64];
            endcase
            return b;
        end
    endfunction

    function automatic logic sign_of(input t_word v, input logic [1:0] wc);
        logic s;
        begin
            unique case (wc)
                SZ_8:    s = v[7];
                SZ_16:   s = v[15];
                SZ_32:   s = v[31];
                default: s = v[63];
            endcase
            return s;
        end
    endfunction

endpackage

// ===== rtl/x86_integer_alu_with_flags_unit.sv =====
// top level of the x86 integer alu: input register, alu logic, result register
// depends on xalu_pkg, xalu_core and assert_macros.svh
// One transaction per clock is accepted and one result per clock is delivered while
// i_out_stall is low. An accepted transaction passes through the input register, the alu
// logic and the result register before o_out_valid rises with its result. The operation
// carries its own flags, so transactions are independent. o_in_stall rises only when both
// registers hold data and i_out_stall is high; an empty input register can still take one
// transaction while a finished result waits.
`include "assert_macros.svh"

module x86_integer_alu_with_flags_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [1:0]  i_width_code,
    input  logic [63:0] i_operand_a,
    input  logic [63:0] i_operand_b,
    input  logic [5:0]  i_flags_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_result,
    output logic [5:0]  o_flags_out
);

    logic                r_in_valid;
    logic [2:0]          r_op;
    logic [1:0]          r_width_code;
    logic [63:0]         r_operand_a;
    logic [63:0]         r_operand_b;
    logic [5:0]          r_flags_in;
    logic                r_out_valid;
    xalu_pkg::t_alu_res  r_res;
    xalu_pkg::t_alu_res  n_res;
    logic                out_adv;
    logic                in_adv;

    assign out_adv    = !r_out_valid || !i_out_stall;
    assign in_adv     = !r_in_valid || out_adv;
    assign o_in_stall = !in_adv;

    xalu_core u_core (
        .i_op         (r_op),
        .i_width_code (r_width_code),
        .i_operand_a  (r_operand_a),
        .i_operand_b  (r_operand_b),
        .i_flags_in   (r_flags_in),
        .o_res        (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_adv) begin
                r_in_valid <= i_in_valid;
            end
            if (out_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_adv && i_in_valid) begin
            r_op         <= i_op;
            r_width_code <= i_width_code;
            r_operand_a  <= i_operand_a;
            r_operand_b  <= i_operand_b;
            r_flags_in   <= i_flags_in;
        end
        if (out_adv && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_res.result;
    assign o_flags_out = r_res.flags;

    `ASSERT_SAME(a_stall_only_when_full, o_in_stall, r_in_valid && r_out_valid && i_out_stall)
    `ASSERT_NEXT(a_accept_fills_input, i_in_valid && !o_in_stall, r_in_valid)
    `ASSERT_NEXT(a_input_moves_to_output, r_in_valid && !i_out_stall, o_out_valid)
    `ASSERT_NEXT(a_not_keeps_flags, r_in_valid && out_adv && (r_op == xalu_pkg::OP_NOT),
                 o_flags_out == $past(r_flags_in))

endmodule

// ===== rtl/xalu_core.sv =====
// result and flag logic for one operation
// depends on xalu_pkg
module xalu_core (
    input  logic [2:0]         i_op,
    input  logic [1:0]         i_width_code,
    input  logic [63:0]        i_operand_a,
    input  logic [63:0]        i_operand_b,
    input  logic [5:0]         i_flags_in,
    output xalu_pkg::t_alu_res o_res
);

    xalu_pkg::t_word  mask;
    xalu_pkg::t_word  a;
    xalu_pkg::t_word  b;
    xalu_pkg::t_word  r;
    logic [64:0]      sum;
    logic [64:0]      diff;
    logic             is_arith;
    logic             is_incdec;
    logic             cf;
    logic             af;
    logic             of;
    xalu_pkg::t_flags f;

    always_comb begin
        mask      = xalu_pkg::size_mask(i_width_code);
        a         = i_operand_a & mask;
        is_incdec = (i_op == xalu_pkg::OP_INC) || (i_op == xalu_pkg::OP_DEC);
        is_arith  = (i_op == xalu_pkg::OP_ADD) || (i_op == xalu_pkg::OP_SUB) || is_incdec;
        b         = is_incdec ? 64'd1 : (i_operand_b & mask);
        sum       = {1'b0, a} + {1'b0, b};
        diff      = {1'b0, a} - {1'b0, b};
        cf        = 1'b0;
        of        = 1'b0;
        unique case (i_op)
            xalu_pkg::OP_ADD, xalu_pkg::OP_INC: begin
                r  = sum[63:0] & mask;
                cf = xalu_pkg::bit_at_size(sum, i_width_code);
                of = xalu_pkg::sign_of((a ^ r) & (b ^ r), i_width_code);
            end
            xalu_pkg::OP_SUB, xalu_pkg::OP_DEC: begin
                r  = diff[63:0] & mask;
                cf = diff[64];
                of = xalu_pkg::sign_of((a ^ b) & (a ^ r), i_width_code);
            end
            xalu_pkg::OP_AND: r = a & b;
            xalu_pkg::OP_OR:  r = a | b;
            xalu_pkg::OP_XOR: r = a ^ b;
            default:          r = ~a & mask;
        endcase
        af = a[4] ^ b[4] ^ r[4];

        f = i_flags_in;
        if (i_op != xalu_pkg::OP_NOT) begin
            f[xalu_pkg::FLAG_PF] = ~^r[7:0];
            f[xalu_pkg::FLAG_ZF] = (r == 64'd0);
            f[xalu_pkg::FLAG_SF] = xalu_pkg::sign_of(r, i_width_code);
            f[xalu_pkg::FLAG_OF] = of;
            if (!is_incdec) begin
                f[xalu_pkg::FLAG_CF] = cf;
            end
            if (is_arith) begin
                f[xalu_pkg::FLAG_AF] = af;
            end
        end
        o_res.result = r;
        o_res.flags  = f;
    end

endmodule
